[hw/rtl/progressive_alnum_cipher_top_assert.svh]
// Assertion macros for the progressive base-36 cipher.
// Used by pac_update in hw/rtl; the includer must provide clk and rst_n.
`ifndef PROGRESSIVE_ALNUM_CIPHER_TOP_ASSERT_SVH
`define PROGRESSIVE_ALNUM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pac_pkg.sv]
// Shared constants, types and helper functions of the progressive base-36 cipher.
// Used by the top, pac_front and pac_update in hw/rtl; depends on nothing.
`default_nettype none

package pac_pkg;

  localparam int KEY_ENTRIES = 24;
  localparam int POS_W       = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
  localparam int LEN_W       = $clog2(KEY_ENTRIES + 1);

  localparam int KEY_LEN_W   = 5;
  localparam int KEY_WORD_W  = 48;
  localparam int KEY_WORDS   = 3;
  localparam int KEY_BITS_W  = KEY_WORDS * KEY_WORD_W;
  localparam int SYM_W       = 6;
  localparam int KEY_SLOTS   = KEY_BITS_W / SYM_W;
  localparam int ALPHA_SIZE  = 36;
  localparam int LETTERS     = 26;
  localparam int CHAR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = KEY_WORD_W;

  localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'd65;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'd97;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [BYTE_W-1:0] ASCII_DIGIT_0 = 8'd48;
  localparam logic [BYTE_W-1:0] ASCII_DIGIT_9 = 8'd57;
  // A digit byte minus this offset lands on symbols 26..35.
  localparam logic [BYTE_W-1:0] DIGIT_OFFSET  = 8'd22;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LENGTH = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_KEY_MID    = 2'd2,
    REG_KEY_HIGH   = 2'd3
  } cfg_reg_t;

  // One transaction leaving the front stage.
  typedef struct packed {
    logic             is_char;
    logic [POS_W-1:0] pos;
    logic [SYM_W-1:0] part;   // (symbol + key symbol) mod 36
  } front_t;

  function automatic logic [SYM_W-1:0] key_symbol_at(
    input logic [KEY_BITS_W-1:0] keys,
    input logic [POS_W-1:0]      idx
  );
    logic [SYM_W-1:0] r;
    r = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (int'(idx) == i) begin
        r = keys[i*SYM_W +: SYM_W];
      end
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] r;
    if (idx < SYM_W'(LETTERS)) begin
      r = CHAR_W'(idx) + ASCII_UPPER_A[CHAR_W-1:0];
    end else begin
      r = CHAR_W'(idx) + DIGIT_OFFSET[CHAR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/progressive_alnum_cipher_top.sv]
// Top level of the progressive base-36 cipher: configuration registers and stage wiring.
// Depends on pac_pkg, pac_front, pac_update (and through it pac_ram).
//
//  Channel  Ports                              Direction  Handshake
//  -------  ---------------------------------  ---------  ---------------------------
//  input    in_op, in_message_byte             in         in_valid / in_stall
//  result   out_cipher_char                    out        out_valid / out_stall
//  config   cfg_index, cfg_wdata               in         cfg_wr_en, no back-pressure
//
// One transaction is taken every cycle while in_stall is low; a letter or digit yields its
// cipher character through the registered read of the count RAM and then the output register.
// Reset is synchronous; the per-entry valid bits of the count RAM clear at once, so there is
// no clearing pass and the block accepts input as soon as reset is released.
// in_stall rises only when a finished result is held by out_stall and the count stage behind
// it is also full; dropped bytes and message starts never produce a result.
`default_nettype none

module progressive_alnum_cipher_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_op,
  input  wire logic [pac_pkg::BYTE_W-1:0]       in_message_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pac_pkg::CHAR_W-1:0]            out_cipher_char,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pac_pkg::*;

  // Configuration registers. The key words are kept as one packed vector so that
  // key symbol i always sits at bits 6i+5..6i.
  logic [KEY_LEN_W-1:0]  key_length_r, key_length_nxt;
  logic [KEY_BITS_W-1:0] key_bits_r, key_bits_nxt;

  logic   accept;
  logic   start;
  logic   busy;
  front_t item;

  always_comb begin
    key_length_nxt = key_length_r;
    key_bits_nxt   = key_bits_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_LENGTH: key_length_nxt = cfg_wdata[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_bits_nxt[0*KEY_WORD_W +: KEY_WORD_W] = cfg_wdata;
        REG_KEY_MID:    key_bits_nxt[1*KEY_WORD_W +: KEY_WORD_W] = cfg_wdata;
        REG_KEY_HIGH:   key_bits_nxt[2*KEY_WORD_W +: KEY_WORD_W] = cfg_wdata;
        default: begin
          key_length_nxt = key_length_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_W'(1);
      key_bits_r   <= '0;
    end else begin
      key_length_r <= key_length_nxt;
      key_bits_r   <= key_bits_nxt;
    end
  end

  // A transaction moves when the count stage is free or draining this cycle.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign start    = accept && (in_op == OP_START);

  pac_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_op),
    .message_byte (in_message_byte),
    .key_length   (key_length_r),
    .key_bits     (key_bits_r),
    .item         (item)
  );

  pac_update u_update (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .start           (start),
    .item            (item),
    .out_stall       (out_stall),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_cipher_char (out_cipher_char)
  );

endmodule

`default_nettype wire

[hw/rtl/pac_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module pac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pac_front.sv]
// Front stage: byte classification, key position tracking and key symbol add.
// Depends on pac_pkg.
`default_nettype none

module pac_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 accept,
  input  wire logic                                 op,
  input  wire logic [pac_pkg::BYTE_W-1:0]           message_byte,
  input  wire logic [pac_pkg::KEY_LEN_W-1:0]        key_length,
  input  wire logic [pac_pkg::KEY_BITS_W-1:0]       key_bits,
  output pac_pkg::front_t                           item
);
  import pac_pkg::*;

  localparam int CMP_W = (LEN_W > KEY_LEN_W) ? LEN_W : KEY_LEN_W;

  logic [POS_W-1:0] key_position_r, key_position_nxt;
  logic [LEN_W-1:0] len_eff;
  logic [CMP_W-1:0] kl_ext;
  logic [POS_W-1:0] pos_use;
  logic [LEN_W:0]   pos_inc;
  logic             is_alnum;
  logic [BYTE_W-1:0] sym_byte;
  logic [SYM_W:0]   sum_ks;
  logic [SYM_W-1:0] key_sym;
  logic [SYM_W-1:0] part;

  always_comb begin
    kl_ext = CMP_W'(key_length);
    if (kl_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (kl_ext > CMP_W'(KEY_ENTRIES)) begin
      len_eff = LEN_W'(KEY_ENTRIES);
    end else begin
      len_eff = LEN_W'(kl_ext);
    end
  end

  // A stale position past the current length falls back to entry zero.
  assign pos_use = (LEN_W'(key_position_r) >= len_eff) ? '0 : key_position_r;
  assign pos_inc = (LEN_W + 1)'(pos_use) + (LEN_W + 1)'(1);

  always_comb begin
    is_alnum = 1'b1;
    sym_byte = '0;
    if (message_byte >= ASCII_UPPER_A && message_byte <= ASCII_UPPER_Z) begin
      sym_byte = message_byte - ASCII_UPPER_A;
    end else if (message_byte >= ASCII_LOWER_A && message_byte <= ASCII_LOWER_Z) begin
      sym_byte = message_byte - ASCII_LOWER_A;
    end else if (message_byte >= ASCII_DIGIT_0 && message_byte <= ASCII_DIGIT_9) begin
      sym_byte = message_byte - DIGIT_OFFSET;
    end else begin
      is_alnum = 1'b0;
    end
  end

  assign key_sym = key_symbol_at(key_bits, pos_use);
  assign sum_ks  = (SYM_W + 1)'(sym_byte[SYM_W-1:0]) + (SYM_W + 1)'(key_sym);

  // The sum stays below 99, so two conditional subtractions finish the reduction.
  always_comb begin
    if (sum_ks >= (SYM_W + 1)'(2 * ALPHA_SIZE)) begin
      part = SYM_W'(sum_ks - (SYM_W + 1)'(2 * ALPHA_SIZE));
    end else if (sum_ks >= (SYM_W + 1)'(ALPHA_SIZE)) begin
      part = SYM_W'(sum_ks - (SYM_W + 1)'(ALPHA_SIZE));
    end else begin
      part = SYM_W'(sum_ks);
    end
  end

  always_comb begin
    key_position_nxt = key_position_r;
    if (accept) begin
      if (op == OP_START) begin
        key_position_nxt = '0;
      end else if (is_alnum) begin
        if (pos_inc >= (LEN_W + 1)'(len_eff)) begin
          key_position_nxt = '0;
        end else begin
          key_position_nxt = POS_W'(pos_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_position_r <= '0;
    end else begin
      key_position_r <= key_position_nxt;
    end
  end

  assign item.is_char = (op == OP_BYTE) && is_alnum;
  assign item.pos     = pos_use;
  assign item.part    = part;

endmodule

`default_nettype wire

[hw/rtl/pac_update.sv]
// Count stage: read-modify-write of the progression counts, forwarding and output register.
// Depends on pac_pkg, pac_ram and the assertion macro header.
`default_nettype none
`include "progressive_alnum_cipher_top_assert.svh"

module pac_update (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        start,
  input  wire pac_pkg::front_t             item,
  input  wire logic                        out_stall,
  output logic                             busy,
  output logic                             out_valid,
  output logic [pac_pkg::CHAR_W-1:0]       out_cipher_char
);
  import pac_pkg::*;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [POS_W-1:0]       s1_pos_r;
  logic [SYM_W-1:0]       s1_part_r;
  logic                   fwd_hit_r;
  logic [SYM_W-1:0]       fwd_data_r;
  logic [KEY_ENTRIES-1:0] vld_r, vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r;

  logic                   load;
  logic                   s1_adv;
  logic                   we;
  logic [SYM_W-1:0]       rdata;
  logic [SYM_W-1:0]       cnt;
  logic [SYM_W-1:0]       cnt_nxt;
  logic [SYM_W:0]         sum_raw;
  logic [SYM_W-1:0]       sum;
  logic [SYM_W-1:0]       mirror;

  assign load   = accept && item.is_char;
  assign s1_adv = !out_valid_r || !out_stall;
  assign busy   = s1_valid_r && !s1_adv;
  assign we     = s1_valid_r && s1_adv;

  pac_ram #(
    .WIDTH (SYM_W),
    .DEPTH (KEY_ENTRIES)
  ) u_count_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (s1_pos_r),
    .wdata   (cnt_nxt),
    .re      (load),
    .raddr   (item.pos),
    .rdata_r (rdata)
  );

  // A count written on the edge that loaded this stage is newer than the RAM read.
  always_comb begin
    if (fwd_hit_r) begin
      cnt = fwd_data_r;
    end else if (vld_r[s1_pos_r]) begin
      cnt = rdata;
    end else begin
      cnt = '0;
    end
  end

  assign cnt_nxt = (cnt == SYM_W'(ALPHA_SIZE - 1)) ? '0 : cnt + SYM_W'(1);
  assign sum_raw = (SYM_W + 1)'(s1_part_r) + (SYM_W + 1)'(cnt);
  assign sum     = (sum_raw >= (SYM_W + 1)'(ALPHA_SIZE)) ?
                   SYM_W'(sum_raw - (SYM_W + 1)'(ALPHA_SIZE)) : SYM_W'(sum_raw);
  assign mirror  = SYM_W'(ALPHA_SIZE - 1) - sum;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // A new message wipes every count; it wins over the write of the item before it.
  always_comb begin
    vld_nxt = vld_r;
    if (start) begin
      vld_nxt = '0;
    end else if (we) begin
      vld_nxt[s1_pos_r] = 1'b1;
    end
  end

  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        fwd_hit_r <= we && (s1_pos_r == item.pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_pos_r   <= item.pos;
      s1_part_r  <= item.part;
      fwd_data_r <= cnt_nxt;
    end
    if (we) begin
      out_char_r <= alpha_char(mirror);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_char = out_char_r;

  `PAC_ASSERT_NEXT(a_start_clears, start, vld_r == '0, "start did not clear the count valid bits")
  `PAC_ASSERT_NOW(a_cnt_range, s1_valid_r, cnt < SYM_W'(ALPHA_SIZE), "progression count out of range")
  `PAC_ASSERT_NEXT(a_hold_stage, busy, s1_valid_r && $stable(s1_pos_r) && $stable(s1_part_r), "stage one changed while blocked")
  `PAC_ASSERT_NOW(a_no_load_busy, busy, !load, "item loaded while stage one was blocked")

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for progressive_alnum_cipher_top: a stimulus table, then random messages.
// Depends on pac_pkg for port widths and codes and on the RTL of the block alone.
`timescale 1ns / 1ps

module tb;
  import pac_pkg::*;

  // Gap between the last expected result and a register write, and the tail at the end.
  localparam int SETTLE_CYCLES    = 6;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int TOTAL_ITEMS      = 1150;

  // Every input starts at a known value; only the processes below change them.
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_op           = OP_START;
  logic [BYTE_W-1:0]     in_message_byte = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [CHAR_W-1:0]     out_cipher_char;
  logic                  cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata       = '0;

  progressive_alnum_cipher_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_message_byte (in_message_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_char (out_cipher_char),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the cipher state and its key registers.
  logic [KEY_LEN_W-1:0]  key_len_shadow;
  logic [KEY_WORD_W-1:0] key_words_shadow [KEY_WORDS];
  int unsigned           msg_pos;
  logic [SYM_W-1:0]      entry_counts [KEY_ENTRIES];

  // Cipher characters still owed by the block, oldest first.
  logic [CHAR_W-1:0] cipher_expected [$];

  int unsigned errors        = 0;
  int unsigned counted_items = 0;
  int unsigned hold_requests = 0;
  bit          sender_gaps   = 1'b1;

  // One row of the opening table. Where known is set, want is the character that the
  // block must produce, worked out by hand; otherwise the shadow model decides.
  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] data;
    logic              known;
    logic [CHAR_W-1:0] want;
  } step_row_t;

  // With the reset key (one symbol, value 0) the output is simply the mirrored sum of
  // the symbol and the running count of entry 0.
  step_row_t opening_rows [24] = '{
    '{OP_START, 8'hFF, 1'b0, 7'd0},   // start with a junk byte
    '{OP_BYTE,  "A",   1'b1, 7'd57},  // 0+0 -> '9'
    '{OP_BYTE,  "a",   1'b1, 7'd56},  // lower case folds, count now 1 -> '8'
    '{OP_BYTE,  "Z",   1'b1, 7'd73},  // 25+2 -> 'I'
    '{OP_BYTE,  "z",   1'b1, 7'd72},  // 25+3 -> 'H'
    '{OP_BYTE,  "0",   1'b1, 7'd70},  // 26+4 -> 'F'
    '{OP_BYTE,  "9",   1'b1, 7'd53},  // 35+5 wraps to 4 -> '5'
    '{OP_BYTE,  "@",   1'b0, 7'd0},   // bytes just outside each class are dropped
    '{OP_BYTE,  "[",   1'b0, 7'd0},
    '{OP_BYTE,  8'h60, 1'b0, 7'd0},
    '{OP_BYTE,  "{",   1'b0, 7'd0},
    '{OP_BYTE,  "/",   1'b0, 7'd0},
    '{OP_BYTE,  ":",   1'b0, 7'd0},
    '{OP_BYTE,  8'h00, 1'b0, 7'd0},
    '{OP_BYTE,  8'hFF, 1'b0, 7'd0},
    '{OP_BYTE,  8'h80, 1'b0, 7'd0},
    '{OP_BYTE,  "A",   1'b1, 7'd51},  // drops left the count at 6 -> '3'
    '{OP_START, 8'h00, 1'b0, 7'd0},
    '{OP_BYTE,  "A",   1'b1, 7'd57},  // counts cleared again -> '9'
    '{OP_BYTE,  "Q",   1'b0, 7'd0},
    '{OP_BYTE,  "5",   1'b0, 7'd0},
    '{OP_BYTE,  "k",   1'b0, 7'd0},
    '{OP_START, "A",   1'b0, 7'd0},   // a letter riding on a start is ignored
    '{OP_BYTE,  "B",   1'b1, 7'd56}   // 1+0 -> '8'
  };

  task automatic reset_shadow();
    key_len_shadow = KEY_LEN_W'(1);
    foreach (key_words_shadow[w]) key_words_shadow[w] = '0;
    msg_pos = 0;
    foreach (entry_counts[k]) entry_counts[k] = '0;
  endtask

  // Advances the shadow state by one transaction and tells whether a character comes out.
  task automatic encipher_step(input logic op, input logic [BYTE_W-1:0] msg,
                               output bit emits, output logic [CHAR_W-1:0] ch);
    int unsigned sym, len, p, ksym, sum, mirrored;
    emits = 1'b0;
    ch    = '0;
    if (op == OP_START) begin
      msg_pos = 0;
      foreach (entry_counts[k]) entry_counts[k] = '0;
      return;
    end
    if (msg >= ASCII_UPPER_A && msg <= ASCII_UPPER_Z) begin
      sym = msg - ASCII_UPPER_A;
    end else if (msg >= ASCII_LOWER_A && msg <= ASCII_LOWER_Z) begin
      sym = msg - ASCII_LOWER_A;
    end else if (msg >= ASCII_DIGIT_0 && msg <= ASCII_DIGIT_9) begin
      sym = msg - ASCII_DIGIT_0 + LETTERS;
    end else begin
      return;
    end
    // A length of zero behaves as one, anything past the table as the full table.
    len = key_len_shadow;
    if (len == 0) len = 1;
    if (len > KEY_ENTRIES) len = KEY_ENTRIES;
    // A position left over from a longer key restarts at entry 0.
    p = msg_pos;
    if (p >= len) p = 0;
    ksym     = key_words_shadow[p / 8][SYM_W * (p % 8) +: SYM_W];
    sum      = (sym + ksym + entry_counts[p]) % ALPHA_SIZE;
    mirrored = ALPHA_SIZE - 1 - sum;
    if (mirrored < LETTERS) begin
      ch = CHAR_W'(ASCII_UPPER_A + mirrored);
    end else begin
      ch = CHAR_W'(ASCII_DIGIT_0 + mirrored - LETTERS);
    end
    entry_counts[p] = SYM_W'((entry_counts[p] + 1) % ALPHA_SIZE);
    p = p + 1;
    if (p >= len) p = 0;
    msg_pos = p;
    emits   = 1'b1;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] alnum_byte();
    case ($urandom_range(0, 2))
      0:       return BYTE_W'(ASCII_UPPER_A + $urandom_range(0, 25));
      1:       return BYTE_W'(ASCII_LOWER_A + $urandom_range(0, 25));
      default: return BYTE_W'(ASCII_DIGIT_0 + $urandom_range(0, 9));
    endcase
  endfunction

  // Style 0: all ones, 1: any bits, 2: every symbol 35, 3: zero, else legal symbols.
  function automatic logic [KEY_WORD_W-1:0] key_word(input int unsigned style);
    logic [KEY_WORD_W-1:0] w;
    w = '0;
    for (int s = 0; s < KEY_WORD_W / SYM_W; s++) begin
      case (style)
        0:       w[s*SYM_W +: SYM_W] = '1;
        1:       w[s*SYM_W +: SYM_W] = SYM_W'($urandom_range(0, 63));
        2:       w[s*SYM_W +: SYM_W] = SYM_W'(ALPHA_SIZE - 1);
        3:       w[s*SYM_W +: SYM_W] = '0;
        default: w[s*SYM_W +: SYM_W] = SYM_W'($urandom_range(0, ALPHA_SIZE - 1));
      endcase
    end
    return w;
  endfunction

  task automatic cfg_write(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (which)
      REG_KEY_LENGTH: key_len_shadow      = value[KEY_LEN_W-1:0];
      REG_KEY_LOW:    key_words_shadow[0] = value;
      REG_KEY_MID:    key_words_shadow[1] = value;
      REG_KEY_HIGH:   key_words_shadow[2] = value;
      default:        ;
    endcase
  endtask

  // Key length register value with random bits above the used field.
  function automatic logic [CFG_DATA_W-1:0] length_word(input int unsigned len);
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    wide[KEY_LEN_W-1:0] = KEY_LEN_W'(len);
    return wide[CFG_DATA_W-1:0];
  endfunction

  // Offers one transaction, waits for the handshake and records what must come out.
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] data,
                           input bit known = 1'b0, input logic [CHAR_W-1:0] want = '0);
    int unsigned gap;
    bit          emits;
    logic [CHAR_W-1:0] ch;
    gap = sender_gaps ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_message_byte <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    encipher_step(op, data, emits, ch);
    if (emits) cipher_expected.push_back(known ? want : ch);
    counted_items++;
  endtask

  // Lets the block run dry: no valid, every owed character delivered, a short tail.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: every accepted character is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (cipher_expected.size() == 0) begin
        errors++;
        $display("%0t: cipher char with nothing expected, got %0d",
                 $time, out_cipher_char);
      end else begin
        if (out_cipher_char !== cipher_expected[0]) begin
          errors++;
          $display("%0t: cipher char mismatch, expected %0d got %0d",
                   $time, cipher_expected[0], out_cipher_char);
        end
        void'(cipher_expected.pop_front());
      end
    end
  end

  // Receiver: random stalls, open stretches, and on request one long hold-off counted
  // here so that the block backs up and stalls its input while the sender keeps offering.
  initial begin : receiver
    int unsigned stall_left, open_left, seen_holds;
    bit          stall_next;
    stall_left = 0;
    open_left  = 0;
    seen_holds = 0;
    forever begin
      @(negedge clk);
      if (seen_holds != hold_requests) begin
        seen_holds = hold_requests;
        stall_left = LONG_HOLD_CYCLES;
        open_left  = 0;
      end
      if (stall_left == 0 && open_left == 0) begin
        case ($urandom_range(0, 9))
          0:          open_left  = $urandom_range(50, 200);
          1, 2, 3, 4: open_left  = $urandom_range(1, 6);
          default:    stall_left = 1 + idle_length();
        endcase
      end
      if (stall_left > 0) begin
        stall_next = 1'b1;
        stall_left--;
      end else begin
        stall_next = 1'b0;
        open_left--;
      end
      out_stall <= stall_next;
    end
  end

  // Main sequence: reset, the opening table, then phases of key settings and messages.
  initial begin : stimulus
    int unsigned phase, messages, span, roll;
    reset_shadow();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[r]) begin
      send_item(opening_rows[r].op, opening_rows[r].data,
                opening_rows[r].known, opening_rows[r].want);
    end

    phase = 0;
    while (counted_items < TOTAL_ITEMS) begin
      // Registers only change once the block has nothing left in flight.
      drain();
      sender_gaps = ($urandom_range(0, 5) != 0);
      case (phase)
        0: begin
          // Longest key, every symbol at the top of the alphabet.
          cfg_write(REG_KEY_LENGTH, length_word(KEY_ENTRIES));
          cfg_write(REG_KEY_LOW,  key_word(2));
          cfg_write(REG_KEY_MID,  key_word(2));
          cfg_write(REG_KEY_HIGH, key_word(2));
        end
        1: begin
          // Zero length acts as one; six-bit symbols above 35 are used as they stand.
          cfg_write(REG_KEY_LENGTH, length_word(0));
          cfg_write(REG_KEY_LOW,  key_word(0));
          cfg_write(REG_KEY_MID,  key_word(0));
          cfg_write(REG_KEY_HIGH, key_word(0));
        end
        2: begin
          // Length field at its maximum, beyond the key table.
          cfg_write(REG_KEY_LENGTH, length_word((1 << KEY_LEN_W) - 1));
          cfg_write(REG_KEY_LOW,  key_word(3));
          cfg_write(REG_KEY_MID,  key_word(3));
          cfg_write(REG_KEY_HIGH, key_word(3));
        end
        default: begin
          if (phase == 3 || $urandom_range(0, 1) == 1) begin
            roll = $urandom_range(0, 9);
            if (roll == 0)      cfg_write(REG_KEY_LENGTH, length_word(0));
            else if (roll == 1) cfg_write(REG_KEY_LENGTH,
                                          length_word($urandom_range(KEY_ENTRIES + 1, 31)));
            else if (roll == 2) cfg_write(REG_KEY_LENGTH, length_word(1));
            else                cfg_write(REG_KEY_LENGTH,
                                          length_word($urandom_range(1, KEY_ENTRIES)));
          end
          if ($urandom_range(0, 1) == 1) cfg_write(REG_KEY_LOW,  key_word($urandom_range(0, 9)));
          if ($urandom_range(0, 1) == 1) cfg_write(REG_KEY_MID,  key_word($urandom_range(0, 9)));
          if ($urandom_range(0, 1) == 1) cfg_write(REG_KEY_HIGH, key_word($urandom_range(0, 9)));
        end
      endcase

      if (phase == 3) begin
        // Back-pressure phase: the receiver holds off while a dense run keeps coming.
        sender_gaps = 1'b0;
        hold_requests++;
        send_item(OP_START, 8'($urandom_range(0, 255)));
        repeat (80) send_item(OP_BYTE, alnum_byte());
      end else begin
        messages = $urandom_range(2, 6);
        for (int m = 0; m < messages; m++) begin
          // The first message of a phase sometimes carries on without a start, so a
          // shortened key meets a position left over from the previous setting.
          if (m > 0 || $urandom_range(0, 9) >= 3) begin
            send_item(OP_START, 8'($urandom_range(0, 255)));
          end
          span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
          for (int k = 0; k < span; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)       send_item(OP_START, 8'($urandom_range(0, 255)));
            else if (roll < 17) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            else                send_item(OP_BYTE, alnum_byte());
          end
        end
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && cipher_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
